/* design/sdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_pkg
// shared constants, codes and types of the smoothstep crossfade block
// ----------------------------------------------------------------------------
package sdc_pkg;

	localparam int MAX_CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS_DEF  = 24;
	localparam int GAIN_BITS_DEF    = 16;

	localparam int REQ_W    = 2;
	localparam int CHAN_W   = 3;
	localparam int RAMP_W   = 14;
	localparam int FRAMES_W = 13;
	localparam int LIN_W    = FRAMES_W + 2;
	localparam int SQ_W     = 2 * FRAMES_W;
	localparam int NUM_W    = 3 * FRAMES_W;

	localparam logic [RAMP_W-1:0] RAMP_MIN   = 14'd1;
	localparam logic [RAMP_W-1:0] RAMP_MAX   = 14'd8192;
	localparam logic [RAMP_W-1:0] RAMP_RESET = 14'd128;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FADE   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY_GO,
		ST_COPY,
		ST_GAIN,
		ST_GAIN_WAIT,
		ST_ANCHOR,
		ST_MIX,
		ST_MIX_WAIT,
		ST_OUT
	} sdc_state_t;

	typedef struct packed {
		logic clear;
		logic copy_start;
		logic rd_en;
		logic wr_en;
	} store_ctl_t;

	function automatic logic [RAMP_W-1:0] ramp_clamp(input logic [RAMP_W-1:0] v);
		logic [RAMP_W-1:0] r;
		if (v < RAMP_MIN) begin
			r = RAMP_MIN;
		end else if (v > RAMP_MAX) begin
			r = RAMP_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* design/sdc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_in_if
// input channel: request words with channel tag and frame end mark
// ----------------------------------------------------------------------------
interface sdc_in_if #(
	parameter int SAMPLE_BITS = sdc_pkg::SAMPLE_BITS_DEF
) ();
	logic                             valid;
	logic                             ready;
	logic [sdc_pkg::REQ_W-1:0]        req_type;
	logic [sdc_pkg::CHAN_W-1:0]       chan;
	logic signed [SAMPLE_BITS-1:0]    sample_in;
	logic                             frame_end;

	modport source (output valid, req_type, chan, sample_in, frame_end, input ready);
	modport sink   (input valid, req_type, chan, sample_in, frame_end, output ready);
endinterface

/* design/sdc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_out_if
// output channel: crossfaded sample words
// ----------------------------------------------------------------------------
interface sdc_out_if #(
	parameter int SAMPLE_BITS = sdc_pkg::SAMPLE_BITS_DEF
) ();
	logic                             valid;
	logic                             ready;
	logic signed [SAMPLE_BITS-1:0]    sample_out;
	logic [sdc_pkg::CHAN_W-1:0]       out_chan;
	logic                             out_frame_end;

	modport source (output valid, sample_out, out_chan, out_frame_end, input ready);
	modport sink   (input valid, sample_out, out_chan, out_frame_end, output ready);
endinterface

/* design/smoothstep_declick_crossfade_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothstep_declick_crossfade_top
// per-frame smoothstep crossfade from held anchors to live audio
// ----------------------------------------------------------------------------
// Audio words come in one at a time on din, each tagged with its channel;
// a word on channel 0 starts a frame. A fade request word arms the ramp,
// a clear word zeroes the per-channel history and the ramp state, and
// neither produces an output word. At the next frame start an armed ramp
// snapshots every channel's last output as its anchor (a sweep through the
// two channel memories), then for ramp_length frames each sample is mixed
// as in*g + anchor*(1-g), with g the smoothstep of the frame position in
// Q1.GAIN_BITS and the mix rounded half up. One word is processed at a
// time: a pass-through sample goes straight to the output register, a
// ramped sample first reads the anchor memory and makes two passes through
// the shared mix multiplier, and a ramped frame start first computes the
// gain with one multiplier for four products and a restoring divider
// producing one quotient bit per cycle. The output register lets the next
// word be taken while a result waits on dout. ramp_length must be written
// through cfg_we/cfg_wdata only while the block is idle, which the block
// itself does not enforce; 0 acts as 1 and values above 8192 act as 8192.
// ----------------------------------------------------------------------------
module smoothstep_declick_crossfade_top #(
	parameter int MAX_CHANNELS = sdc_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = sdc_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_BITS    = sdc_pkg::GAIN_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sdc_in_if.sink                      din,
	sdc_out_if.source                   dout,
	input  logic                        cfg_we,
	input  logic [sdc_pkg::RAMP_W-1:0]  cfg_wdata
);

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// fsm
	sdc_pkg::sdc_state_t state_q;
	sdc_pkg::sdc_state_t state_d;

	// ramp control
	logic [sdc_pkg::RAMP_W-1:0]    ramp_length_q;
	logic [sdc_pkg::RAMP_W-1:0]    ramp_now;
	logic                          fade_armed_q;
	logic [sdc_pkg::FRAMES_W-1:0]  frames_done_q;
	logic [sdc_pkg::RAMP_W-1:0]    frames_left_q;
	logic [GAIN_BITS:0]            frame_gain_q;
	logic                          in_ramp_q;

	// word being processed
	logic [sdc_pkg::CHAN_W-1:0]    chan_q;
	logic                          fe_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic                          chan_ok;

	// output register
	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic [sdc_pkg::CHAN_W-1:0]    out_chan_q;
	logic                          out_fe_q;
	logic                          out_free;
	logic                          out_load;

	logic                          accept;
	sdc_pkg::store_ctl_t           store_ctl;
	logic                          copy_busy;
	logic signed [SAMPLE_BITS-1:0] anchor_data;
	logic signed [SAMPLE_BITS-1:0] anchor_sel;
	logic                          gain_start;
	logic                          gain_done;
	logic [GAIN_BITS:0]            gain;
	logic                          mix_start;
	logic                          mix_done;
	logic signed [SAMPLE_BITS-1:0] mix_result;

	assign din.ready = (state_q == sdc_pkg::ST_IDLE);
	assign accept    = din.valid & din.ready;
	assign ramp_now  = sdc_pkg::ramp_clamp(ramp_length_q);
	// channels beyond the memory have a zero anchor and are not remembered
	assign chan_ok   = (32'(chan_q) < MAX_CHANNELS);
	assign out_free  = !out_vld_q || dout.ready;
	assign anchor_sel = chan_ok ? anchor_data : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdc_pkg::ST_IDLE: begin
				if (accept && din.req_type == sdc_pkg::REQ_SAMPLE) begin
					if (din.chan == '0) begin
						if (fade_armed_q) begin
							state_d = sdc_pkg::ST_COPY_GO;
						end else if (frames_left_q != '0) begin
							state_d = sdc_pkg::ST_GAIN;
						end else begin
							state_d = sdc_pkg::ST_OUT;
						end
					end else if (in_ramp_q) begin
						state_d = sdc_pkg::ST_ANCHOR;
					end else begin
						state_d = sdc_pkg::ST_OUT;
					end
				end
			end
			sdc_pkg::ST_COPY_GO: state_d = sdc_pkg::ST_COPY;
			sdc_pkg::ST_COPY: begin
				if (!copy_busy) begin
					state_d = sdc_pkg::ST_GAIN;
				end
			end
			sdc_pkg::ST_GAIN: state_d = sdc_pkg::ST_GAIN_WAIT;
			sdc_pkg::ST_GAIN_WAIT: begin
				if (gain_done) begin
					state_d = sdc_pkg::ST_ANCHOR;
				end
			end
			sdc_pkg::ST_ANCHOR: state_d = sdc_pkg::ST_MIX;
			sdc_pkg::ST_MIX: state_d = sdc_pkg::ST_MIX_WAIT;
			sdc_pkg::ST_MIX_WAIT: begin
				if (mix_done) begin
					state_d = sdc_pkg::ST_OUT;
				end
			end
			sdc_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = sdc_pkg::ST_IDLE;
				end
			end
			default: state_d = sdc_pkg::ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		out_load             = (state_q == sdc_pkg::ST_OUT) && out_free;
		store_ctl            = '0;
		store_ctl.clear      = accept && (din.req_type == sdc_pkg::REQ_CLEAR);
		store_ctl.copy_start = (state_q == sdc_pkg::ST_COPY_GO);
		store_ctl.rd_en      = (state_q == sdc_pkg::ST_ANCHOR) && chan_ok;
		// every output sample on a channel inside the memory becomes its last output
		store_ctl.wr_en      = out_load && chan_ok;
		gain_start           = (state_q == sdc_pkg::ST_GAIN);
		mix_start            = (state_q == sdc_pkg::ST_MIX);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sdc_pkg::ST_IDLE;
			ramp_length_q <= sdc_pkg::RAMP_RESET;
			fade_armed_q  <= 1'b0;
			frames_done_q <= '0;
			frames_left_q <= '0;
			frame_gain_q  <= '0;
			in_ramp_q     <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ramp_length_q <= cfg_wdata;
			end
			if (accept) begin
				case (din.req_type)
					sdc_pkg::REQ_FADE: fade_armed_q <= 1'b1;
					sdc_pkg::REQ_CLEAR: begin
						fade_armed_q  <= 1'b0;
						frames_done_q <= '0;
						frames_left_q <= '0;
						frame_gain_q  <= '0;
						in_ramp_q     <= 1'b0;
					end
					sdc_pkg::REQ_SAMPLE: begin
						// frame start: an armed ramp (re)starts here
						if (din.chan == '0) begin
							if (fade_armed_q) begin
								fade_armed_q  <= 1'b0;
								frames_done_q <= '0;
								frames_left_q <= ramp_now;
							end else if (frames_left_q == '0) begin
								in_ramp_q <= 1'b0;
							end
						end
					end
					default: ;
				endcase
			end
			// ramp frame: take the new gain and advance the frame counters
			if (state_q == sdc_pkg::ST_GAIN_WAIT && gain_done) begin
				frame_gain_q  <= gain;
				in_ramp_q     <= 1'b1;
				frames_done_q <= frames_done_q + 1'b1;
				frames_left_q <= frames_left_q - 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q <= din.chan;
			fe_q   <= din.frame_end;
			res_q  <= din.sample_in;
		end else if (mix_done) begin
			res_q <= mix_result;
		end
		if (out_load) begin
			out_sample_q <= res_q;
			out_chan_q   <= chan_q;
			out_fe_q     <= fe_q;
		end
	end

	assign dout.valid         = out_vld_q;
	assign dout.sample_out    = out_sample_q;
	assign dout.out_chan      = out_chan_q;
	assign dout.out_frame_end = out_fe_q;

	sdc_store #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.AW           (AW)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (store_ctl),
		.rd_addr     (AW'(chan_q)),
		.wr_addr     (AW'(chan_q)),
		.wr_data     (res_q),
		.copy_busy   (copy_busy),
		.anchor_data (anchor_data)
	);

	// d = R - 1, R never exceeds 8192 so it fits the frame counter width
	sdc_gain #(
		.GAIN_BITS (GAIN_BITS)
	) u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gain_start),
		.n      (frames_done_q),
		.d      (sdc_pkg::FRAMES_W'(ramp_now - 1'b1)),
		.done   (gain_done),
		.gain   (gain)
	);

	sdc_mix #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.GAIN_BITS   (GAIN_BITS)
	) u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.x      (res_q),
		.a      (anchor_sel),
		.g      (frame_gain_q),
		.done   (mix_done),
		.result (mix_result)
	);

	// the last-output memory is never written while the snapshot sweep reads it
	a_copy_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		copy_busy |-> !store_ctl.wr_en)
		else $error("last output written during anchor snapshot");

	// a mix only runs inside a ramped frame
	a_mix_in_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		mix_start |-> in_ramp_q)
		else $error("mix started outside a ramp");

	// gain results only arrive while the fsm waits for them
	a_gain_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		gain_done |-> (state_q == sdc_pkg::ST_GAIN_WAIT))
		else $error("gain done outside gain wait");

	// a gain is only computed for a frame that is still left in the ramp
	a_gain_frames_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdc_pkg::ST_GAIN) |-> (frames_left_q != '0))
		else $error("gain requested with no ramp frames left");

endmodule

/* design/sdc_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_store
// per-channel memories: last output and anchor, with snapshot sweep
// ----------------------------------------------------------------------------
module sdc_store #(
	parameter int MAX_CHANNELS = sdc_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = sdc_pkg::SAMPLE_BITS_DEF,
	parameter int AW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdc_pkg::store_ctl_t           ctl,
	input  logic [AW-1:0]                 rd_addr,
	input  logic [AW-1:0]                 wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	output logic                          copy_busy,
	output logic signed [SAMPLE_BITS-1:0] anchor_data
);

	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_CHANNELS - 1);

	logic signed [SAMPLE_BITS-1:0] last_mem [MAX_CHANNELS];
	logic signed [SAMPLE_BITS-1:0] anc_mem  [MAX_CHANNELS];

	logic [MAX_CHANNELS-1:0]       last_vld_q;
	logic [MAX_CHANNELS-1:0]       anc_vld_q;
	logic                          sweep_q;
	logic [AW-1:0]                 sweep_idx_q;
	logic                          cp_go_s1;
	logic [AW-1:0]                 cp_idx_s1;
	logic signed [SAMPLE_BITS-1:0] cp_data_s1;
	logic signed [SAMPLE_BITS-1:0] anc_rd_s1;
	logic                          anc_vld_s1;

	// memory ports
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			last_mem[wr_addr] <= wr_data;
		end
		cp_data_s1 <= last_mem[sweep_idx_q];
		cp_idx_s1  <= sweep_idx_q;
		if (cp_go_s1) begin
			anc_mem[cp_idx_s1] <= cp_data_s1;
		end
		if (ctl.rd_en) begin
			anc_rd_s1 <= anc_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b0;
			sweep_idx_q <= '0;
			cp_go_s1    <= 1'b0;
			last_vld_q  <= '0;
			anc_vld_q   <= '0;
			anc_vld_s1  <= 1'b0;
		end else begin
			cp_go_s1 <= sweep_q;
			if (ctl.copy_start) begin
				sweep_q     <= 1'b1;
				sweep_idx_q <= '0;
				anc_vld_q   <= last_vld_q;
			end else if (sweep_q) begin
				if (sweep_idx_q == LAST_IDX) begin
					sweep_q <= 1'b0;
				end else begin
					sweep_idx_q <= sweep_idx_q + 1'b1;
				end
			end
			if (ctl.wr_en) begin
				last_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				anc_vld_s1 <= anc_vld_q[rd_addr];
			end
			// clear wins over everything, entries read as zero afterwards
			if (ctl.clear) begin
				last_vld_q <= '0;
				anc_vld_q  <= '0;
			end
		end
	end

	assign copy_busy   = sweep_q | cp_go_s1;
	assign anchor_data = anc_vld_s1 ? anc_rd_s1 : '0;

endmodule

/* design/sdc_gain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_gain
// smoothstep gain n^2(3d-2n)/d^3 with one shared multiplier and a
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sdc_gain #(
	parameter int GAIN_BITS = sdc_pkg::GAIN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sdc_pkg::FRAMES_W-1:0]  n,
	input  logic [sdc_pkg::FRAMES_W-1:0]  d,
	output logic                          done,
	output logic [GAIN_BITS:0]            gain
);

	localparam int QW        = GAIN_BITS + 1;
	localparam int LAST_STEP = GAIN_BITS + 4;
	localparam int STEP_W    = $clog2(LAST_STEP + 1);
	localparam int REM_W     = sdc_pkg::NUM_W + 1;
	localparam int PROD_W    = sdc_pkg::SQ_W + sdc_pkg::LIN_W;

	localparam logic [STEP_W-1:0] STP_SQN  = STEP_W'(0);
	localparam logic [STEP_W-1:0] STP_SQD  = STEP_W'(1);
	localparam logic [STEP_W-1:0] STP_NUM  = STEP_W'(2);
	localparam logic [STEP_W-1:0] STP_D3   = STEP_W'(3);
	localparam logic [STEP_W-1:0] STP_INT  = STEP_W'(4);
	localparam logic [STEP_W-1:0] STP_LAST = STEP_W'(LAST_STEP);
	localparam logic [QW-1:0]     GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [sdc_pkg::FRAMES_W-1:0]  n_q;
	logic [sdc_pkg::FRAMES_W-1:0]  d_q;
	logic [sdc_pkg::SQ_W-1:0]      sqn_q;
	logic [sdc_pkg::SQ_W-1:0]      sqd_q;
	logic [sdc_pkg::NUM_W-1:0]     num_q;
	logic [sdc_pkg::NUM_W-1:0]     d3_q;
	logic [REM_W-1:0]              rem_q;
	logic [QW-1:0]                 quo_q;

	logic [sdc_pkg::LIN_W-1:0]     lin;
	logic [sdc_pkg::SQ_W-1:0]      mul_a;
	logic [sdc_pkg::LIN_W-1:0]     mul_b;
	logic [PROD_W-1:0]             prod;
	logic [REM_W-1:0]              rem_sh;
	logic [REM_W-1:0]              trial;
	logic                          ge;

	// 3d - 2n, never negative since n is clamped to d
	assign lin = sdc_pkg::LIN_W'(d_q) + sdc_pkg::LIN_W'({d_q, 1'b0})
		- sdc_pkg::LIN_W'({n_q, 1'b0});

	always_comb begin
		case (step_q)
			STP_SQN: begin
				mul_a = sdc_pkg::SQ_W'(n_q);
				mul_b = sdc_pkg::LIN_W'(n_q);
			end
			STP_SQD: begin
				mul_a = sdc_pkg::SQ_W'(d_q);
				mul_b = sdc_pkg::LIN_W'(d_q);
			end
			STP_NUM: begin
				mul_a = sqn_q;
				mul_b = lin;
			end
			default: begin
				mul_a = sqd_q;
				mul_b = sdc_pkg::LIN_W'(d_q);
			end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign rem_sh = {rem_q[REM_W-2:0], 1'b0};
	assign ge     = rem_sh >= REM_W'(d3_q);
	assign trial  = rem_sh - REM_W'(d3_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				// a one-frame ramp has unity gain straight away
				if (d == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (step_q == STP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= (n > d) ? d : n;
			d_q <= d;
			if (d == '0) begin
				quo_q <= GAIN_ONE;
			end
		end else if (busy_q) begin
			case (step_q)
				STP_SQN: sqn_q <= prod[sdc_pkg::SQ_W-1:0];
				STP_SQD: sqd_q <= prod[sdc_pkg::SQ_W-1:0];
				STP_NUM: num_q <= prod[sdc_pkg::NUM_W-1:0];
				STP_D3:  d3_q  <= prod[sdc_pkg::NUM_W-1:0];
				STP_INT: begin
					// integer bit: num never exceeds d^3
					if (num_q >= d3_q) begin
						rem_q <= REM_W'(num_q - d3_q);
						quo_q <= QW'(1);
					end else begin
						rem_q <= REM_W'(num_q);
						quo_q <= '0;
					end
				end
				default: begin
					rem_q <= ge ? trial : rem_sh;
					quo_q <= {quo_q[QW-2:0], ge};
				end
			endcase
		end
	end

	assign done = done_q;
	assign gain = quo_q;

endmodule

/* design/sdc_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_mix
// convex mix in*g + anchor*(1-g), one multiplier for both products,
// rounding half up
// ----------------------------------------------------------------------------
module sdc_mix #(
	parameter int SAMPLE_BITS = sdc_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_BITS   = sdc_pkg::GAIN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [SAMPLE_BITS-1:0] a,
	input  logic [GAIN_BITS:0]            g,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int GW    = GAIN_BITS + 1;
	localparam int PW    = SAMPLE_BITS + GW + 1;
	localparam int ACC_W = PW + 1;

	localparam logic [GW-1:0]           ONE  = {1'b1, {GAIN_BITS{1'b0}}};
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (GAIN_BITS - 1);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MX   = 2'd1;
	localparam logic [1:0] PH_MA   = 2'd2;
	localparam logic [1:0] PH_RND  = 2'd3;

	logic [1:0]                    ph_q;
	logic                          done_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic [GW-1:0]                 g_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [SAMPLE_BITS-1:0] res_q;

	logic signed [SAMPLE_BITS-1:0] op_s;
	logic [GW-1:0]                 op_g;
	logic signed [PW-1:0]          prod;
	logic signed [ACC_W-1:0]       rnd;

	assign op_s = (ph_q == PH_MX) ? x_q : a_q;
	assign op_g = (ph_q == PH_MX) ? g_q : GW'(ONE - g_q);
	assign prod = op_s * $signed({1'b0, op_g});
	assign rnd  = (acc_q + HALF) >>> GAIN_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: if (start) begin
					ph_q <= PH_MX;
				end
				PH_MX:   ph_q <= PH_MA;
				PH_MA:   ph_q <= PH_RND;
				PH_RND: begin
					ph_q   <= PH_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			a_q <= a;
			g_q <= g;
		end
		if (ph_q == PH_MX) begin
			acc_q <= ACC_W'(prod);
		end else if (ph_q == PH_MA) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
		if (ph_q == PH_RND) begin
			res_q <= rnd[SAMPLE_BITS-1:0];
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* verif/tb_smoothstep_declick_crossfade_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothstep_declick_crossfade_top
// self-checking bench for the smoothstep de-click crossfade block
// ----------------------------------------------------------------------------
// A queue of request words feeds a clocked driver and a clocked monitor
// drains the output channel. Each accepted word runs through a local model
// of the crossfade (per-channel history, anchors, armed flag, frame counters,
// smoothstep gain, rounded convex mix). Every output word is checked field by
// field against the oldest predicted word. A directed opening runs first,
// then random framed audio with fade, clear and junk words under a series of
// ramp lengths, the extremes among them. Both sides idle at random, and the
// receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_smoothstep_declick_crossfade_top;

	localparam int NCH = sdc_pkg::MAX_CHANNELS_DEF;
	localparam int SB  = sdc_pkg::SAMPLE_BITS_DEF;
	localparam int GB  = sdc_pkg::GAIN_BITS_DEF;

	// request code the block must ignore
	localparam logic [sdc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam logic [SB-1:0] S_MAX  = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] S_MIN  = {1'b1, {(SB-1){1'b0}}};
	localparam logic [SB-1:0] S_ZERO = '0;
	localparam logic [SB-1:0] S_NEG1 = '1;

	localparam longint GAIN_UNITY = longint'(1) << GB;
	localparam longint GAIN_HALF  = longint'(1) << (GB - 1);

	localparam int IDLE_TAIL       = 64;   // idle wait, longer than the slowest word incl. gain and anchor copy
	localparam int LONG_HOLD       = 400;  // receiver hold-off, in cycles
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct packed {
		logic [sdc_pkg::REQ_W-1:0]  req;
		logic [sdc_pkg::CHAN_W-1:0] chan;
		logic [SB-1:0]              sample;
		logic                       fe;
	} audio_req_t;

	typedef struct packed {
		logic [SB-1:0]              sample;
		logic [sdc_pkg::CHAN_W-1:0] chan;
		logic                       fe;
	} faded_word_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [sdc_pkg::RAMP_W-1:0]   cfg_wdata;

	sdc_in_if  audio_in ();
	sdc_out_if audio_out ();

	smoothstep_declick_crossfade_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (audio_in),
		.dout      (audio_out),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// stimulus and expectations
	audio_req_t  req_q[$];
	faded_word_t faded_q[$];
	int          items_made;
	int          fails;

	// local copy of the crossfade state
	logic [sdc_pkg::RAMP_W-1:0]   ramp_reg;
	logic [SB-1:0]                last_out [NCH];
	logic [SB-1:0]                anchor [NCH];
	logic                         armed;
	logic [sdc_pkg::FRAMES_W-1:0] frames_done;
	logic [sdc_pkg::RAMP_W-1:0]   frames_left;
	logic [GB:0]                  gain_q;
	logic                         ramping;

	// driver and monitor bookkeeping
	audio_req_t on_bus;
	int         tx_gap;
	int         words_sent;
	bit         tx_calm;
	int         rx_stall;
	int         rx_hold;
	int         words_seen;
	bit         rx_calm;

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// model of the block
	// ------------------------------------------------------------------

	task automatic clear_history();
		foreach (last_out[i]) begin
			last_out[i] = '0;
			anchor[i]   = '0;
		end
		armed       = 1'b0;
		frames_done = '0;
		frames_left = '0;
		gain_q      = '0;
		ramping     = 1'b0;
	endtask

	// floor(n^2 (3d - 2n) 2^GB / d^3), d = len - 1, n clamped to d
	function automatic logic [GB:0] smooth_gain(
		input logic [sdc_pkg::FRAMES_W-1:0] pos,
		input logic [sdc_pkg::RAMP_W-1:0]   len);
		longint unsigned d, n, num, d3, q, rem;
		logic [GB:0]     g;
		if (len <= 1) begin
			return GAIN_UNITY[GB:0];
		end
		d = 64'(len) - 64'd1;
		n = 64'(pos);
		if (n > d) begin
			n = d;
		end
		num = n * n * (3 * d - 2 * n);
		d3  = d * d * d;
		q   = num / d3;
		rem = num % d3;
		g   = (GB+1)'((q << GB) + ((rem << GB) / d3));
		return g;
	endfunction

	task automatic predict_crossfade(input audio_req_t rq);
		logic [sdc_pkg::RAMP_W-1:0] len;
		longint                     x, a, g, mix, rounded;
		faded_word_t                w;
		case (rq.req)
			sdc_pkg::REQ_FADE: begin
				armed = 1'b1;
			end
			sdc_pkg::REQ_CLEAR: begin
				clear_history();
			end
			sdc_pkg::REQ_SAMPLE: begin
				// channel 0 opens a frame: maybe start a ramp, then step it
				if (rq.chan == '0) begin
					len = ramp_reg;
					if (len < sdc_pkg::RAMP_MIN) begin
						len = sdc_pkg::RAMP_MIN;
					end else if (len > sdc_pkg::RAMP_MAX) begin
						len = sdc_pkg::RAMP_MAX;
					end
					if (armed) begin
						armed       = 1'b0;
						frames_done = '0;
						frames_left = len;
						foreach (anchor[i]) begin
							anchor[i] = last_out[i];
						end
					end
					if (frames_left != '0) begin
						gain_q      = smooth_gain(frames_done, len);
						ramping     = 1'b1;
						frames_done = frames_done + 1'b1;
						frames_left = frames_left - 1'b1;
					end else begin
						ramping = 1'b0;
					end
				end
				w.chan   = rq.chan;
				w.fe     = rq.fe;
				w.sample = rq.sample;
				if (ramping) begin
					x = 64'($signed(rq.sample));
					g = 64'(gain_q);
					a = (rq.chan < NCH) ? 64'($signed(anchor[rq.chan])) : 64'sd0;
					mix     = x * g + a * (GAIN_UNITY - g);
					rounded = (mix + GAIN_HALF) >>> GB;
					w.sample = rounded[SB-1:0];
				end
				if (rq.chan < NCH) begin
					last_out[rq.chan] = w.sample;
				end
				faded_q.push_back(w);
			end
			default: ;
		endcase
	endtask

	// mostly no gap, some short, a few long; none at all in calm stretches
	function automatic int pick_gap(input bit calm);
		int p;
		if (calm) begin
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 70) begin
			return 0;
		end else if (p < 90) begin
			return $urandom_range(1, 3);
		end else if (p < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// driver: one word on the bus at a time, prediction on acceptance
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			audio_in.valid <= 1'b0;
		end else begin
			if (audio_in.valid && audio_in.ready) begin
				predict_crossfade(on_bus);
				words_sent++;
				if (words_sent % 128 == 0) begin
					tx_calm = ($urandom_range(0, 3) == 0);
				end
			end
			// bus is free for a new word after this edge
			if (!audio_in.valid || audio_in.ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					audio_in.valid <= 1'b0;
				end else if (req_q.size() != 0) begin
					on_bus = req_q.pop_front();
					audio_in.valid     <= 1'b1;
					audio_in.req_type  <= on_bus.req;
					audio_in.chan      <= on_bus.chan;
					audio_in.sample_in <= on_bus.sample;
					audio_in.frame_end <= on_bus.fe;
					tx_gap = pick_gap(tx_calm);
				end else begin
					audio_in.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: check each output word, random stalls, one long hold-off
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		faded_word_t want;
		if (!arst_n) begin
			audio_out.ready <= 1'b0;
		end else begin
			if (audio_out.valid && audio_out.ready) begin
				if (faded_q.size() == 0) begin
					$error("unexpected word: sample_out %0d out_chan %0d out_frame_end %0d",
						$signed(audio_out.sample_out), audio_out.out_chan,
						audio_out.out_frame_end);
					fails++;
				end else begin
					want = faded_q.pop_front();
					if (audio_out.sample_out !== want.sample) begin
						$error("sample_out: expected %0d, got %0d",
							$signed(want.sample), $signed(audio_out.sample_out));
						fails++;
					end
					if (audio_out.out_chan !== want.chan) begin
						$error("out_chan: expected %0d, got %0d",
							want.chan, audio_out.out_chan);
						fails++;
					end
					if (audio_out.out_frame_end !== want.fe) begin
						$error("out_frame_end: expected %0d, got %0d",
							want.fe, audio_out.out_frame_end);
						fails++;
					end
				end
				words_seen++;
				// long hold-off while the driver keeps offering, block backs up
				if (words_seen == 200) begin
					rx_hold = LONG_HOLD;
				end
				if (words_seen % 100 == 0) begin
					rx_calm = ($urandom_range(0, 3) == 0);
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				audio_out.ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				audio_out.ready <= 1'b0;
			end else begin
				audio_out.ready <= 1'b1;
				rx_stall = pick_gap(rx_calm);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(0, 15))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return S_ZERO;
			3:       return S_NEG1;
			default: return SB'($urandom());
		endcase
	endfunction

	task automatic queue_req(input logic [sdc_pkg::REQ_W-1:0] rq, input int c,
	                         input logic [SB-1:0] s, input logic fe);
		audio_req_t it;
		it.req    = rq;
		it.chan   = sdc_pkg::CHAN_W'(c);
		it.sample = s;
		it.fe     = fe;
		req_q.push_back(it);
		if (rq != REQ_UNUSED) begin
			items_made++;
		end
	endtask

	// control word (fade, clear or unused code) with junk in the other fields
	task automatic queue_ctl(input logic [sdc_pkg::REQ_W-1:0] rq);
		queue_req(rq, $urandom_range(0, 7), SB'($urandom()), 1'($urandom_range(0, 1)));
	endtask

	// channels 0..n-1 in order, end mark on the last; optional fade inside
	task automatic queue_frame(input int n, input int fade_at);
		for (int c = 0; c < n; c++) begin
			if (c == fade_at) begin
				queue_ctl(sdc_pkg::REQ_FADE);
			end
			queue_req(sdc_pkg::REQ_SAMPLE, c, pick_sample(), c == n - 1);
		end
	endtask

	// wait at a falling edge so every posedge update has settled
	task automatic wait_drained();
		while (req_q.size() != 0 || audio_in.valid || faded_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_ramp(input logic [sdc_pkg::RAMP_W-1:0] v);
		wait_drained();
		// fade and clear words give no output, so let the block settle
		repeat (IDLE_TAIL) @(negedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		ramp_reg  = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(input int target, input bit pause_midway);
		int goal;
		int p;
		int n;
		bit paused;
		goal   = items_made + target;
		paused = 1'b0;
		while (items_made < goal) begin
			// sender waits once for every output before going on
			if (pause_midway && !paused && items_made >= goal - target / 2) begin
				paused = 1'b1;
				wait_drained();
			end
			p = $urandom_range(0, 99);
			n = $urandom_range(1, NCH);
			if (p < 78) begin
				queue_frame(n, -1);
			end else if (p < 86) begin
				queue_ctl(sdc_pkg::REQ_FADE);
			end else if (p < 91) begin
				queue_frame(n, $urandom_range(0, n - 1));
			end else if (p < 94) begin
				queue_ctl(sdc_pkg::REQ_CLEAR);
			end else if (p < 96) begin
				queue_ctl(REQ_UNUSED);
			end else begin
				// stray sample, any channel, any end mark
				queue_req(sdc_pkg::REQ_SAMPLE, $urandom_range(0, 7), pick_sample(),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [sdc_pkg::RAMP_W-1:0] ramp_plan [9];

		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		audio_in.valid     = 1'b0;
		audio_in.req_type  = sdc_pkg::REQ_SAMPLE;
		audio_in.chan      = '0;
		audio_in.sample_in = '0;
		audio_in.frame_end = 1'b0;
		audio_out.ready    = 1'b0;
		items_made = 0;
		fails      = 0;
		tx_gap     = 0;
		words_sent = 0;
		tx_calm    = 1'b0;
		rx_stall   = 0;
		rx_hold    = 0;
		words_seen = 0;
		rx_calm    = 1'b0;
		ramp_reg   = sdc_pkg::RAMP_RESET;
		clear_history();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed opening at the reset ramp length
		queue_req(sdc_pkg::REQ_SAMPLE, 0, S_MAX, 1'b0);
		queue_req(sdc_pkg::REQ_SAMPLE, 1, S_MIN, 1'b0);
		queue_req(sdc_pkg::REQ_SAMPLE, 7, S_NEG1, 1'b1);
		queue_ctl(REQ_UNUSED);                             // ignored, no output
		queue_ctl(sdc_pkg::REQ_FADE);
		queue_req(sdc_pkg::REQ_SAMPLE, 0, S_ZERO, 1'b0);   // ramp starts, gain zero
		queue_req(sdc_pkg::REQ_SAMPLE, 1, S_MAX, 1'b0);
		queue_req(sdc_pkg::REQ_SAMPLE, 7, S_MIN, 1'b1);
		queue_req(sdc_pkg::REQ_SAMPLE, 0, S_MIN, 1'b0);
		queue_req(sdc_pkg::REQ_SAMPLE, 1, S_MAX, 1'b1);
		queue_ctl(sdc_pkg::REQ_FADE);                      // request while a ramp runs
		queue_req(sdc_pkg::REQ_SAMPLE, 0, S_MAX, 1'b0);    // ramp restarts here
		queue_req(sdc_pkg::REQ_SAMPLE, 7, S_MAX, 1'b1);
		queue_ctl(sdc_pkg::REQ_CLEAR);
		queue_req(sdc_pkg::REQ_SAMPLE, 0, S_MIN, 1'b0);
		queue_req(sdc_pkg::REQ_SAMPLE, 1, S_ZERO, 1'b1);
		queue_ctl(sdc_pkg::REQ_FADE);
		queue_ctl(sdc_pkg::REQ_CLEAR);                     // clear disarms the fade
		queue_req(sdc_pkg::REQ_SAMPLE, 0, S_MAX, 1'b1);
		queue_ctl(sdc_pkg::REQ_FADE);
		queue_req(sdc_pkg::REQ_SAMPLE, 3, S_MAX, 1'b0);    // not a frame start
		queue_req(sdc_pkg::REQ_SAMPLE, 0, S_NEG1, 1'b1);   // ramp starts

		random_traffic(ITEMS_PER_PHASE, 1'b1);

		// zero acts as one, all-ones as the upper clamp
		ramp_plan[0] = 14'd1;
		ramp_plan[1] = 14'd0;
		ramp_plan[2] = 14'd2;
		ramp_plan[3] = 14'd3;
		ramp_plan[4] = '1;
		ramp_plan[5] = sdc_pkg::RAMP_W'($urandom_range(4, 48));
		ramp_plan[6] = sdc_pkg::RAMP_MAX;
		ramp_plan[7] = sdc_pkg::RAMP_MAX - 1'b1;
		ramp_plan[8] = sdc_pkg::RAMP_RESET;
		foreach (ramp_plan[i]) begin
			write_ramp(ramp_plan[i]);
			random_traffic(ITEMS_PER_PHASE, 1'b0);
		end

		wait_drained();
		repeat (IDLE_TAIL) @(posedge clk);
		if (fails == 0) begin
			$display("smoothstep_declick_crossfade_top: match");
		end else begin
			$display("smoothstep_declick_crossfade_top: mismatch");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("smoothstep_declick_crossfade_top: mismatch");
		$finish;
	end

endmodule
